>>> rtl/assert_macros.svh
// Assertion helpers used by the validator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/utv_pkg.sv
`timescale 1ns / 1ps

package utv_pkg;

   // Code point assembly width
   localparam int CODE_W = 21;

   typedef logic [7:0]        byte_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [1:0]        class_type;

   // Sequence length minus one
   localparam class_type CLASS_NONE  = 2'd0;
   localparam class_type CLASS_TWO   = 2'd1;
   localparam class_type CLASS_THREE = 2'd2;
   localparam class_type CLASS_FOUR  = 2'd3;

   // Byte markers
   localparam byte_type BYTE_TERM  = 8'h00;
   localparam byte_type BYTE_SPACE = 8'h20;
   localparam byte_type BYTE_DEL   = 8'h7f;
   localparam byte_type CONT_MASK  = 8'hc0;
   localparam byte_type CONT_TAG   = 8'h80;

   // Code point limits
   localparam code_type MIN_TWO    = 21'h00080;
   localparam code_type MIN_THREE  = 21'h00800;
   localparam code_type MIN_FOUR   = 21'h10000;
   localparam code_type CODE_MAX   = 21'h10ffff;
   localparam code_type SURR_LOW   = 21'h00d800;
   localparam code_type SURR_HIGH  = 21'h00dfff;

endpackage

>>> rtl/utf8_text_validator.sv
`timescale 1ns / 1ps
// Channel   Direction  Width  Fields (low bit up)
// req_      in         8      tdata: text_byte[7:0]
// rsp_      out        8      tdata: string_ok[0], zeros above
//
// Each byte is captured in an input register, checked against the sequence
// state in the next cycle, and a zero byte writes the verdict into the result
// register. One byte is accepted every cycle unless a held zero byte waits.
// Reset (synchronous, active high) clears all string state and both valids.
// A waiting result holds a following zero byte in the input register, and with
// it the whole input, until the result is taken; other bytes keep flowing.

`include "assert_macros.svh"

module utf8_text_validator #(
   parameter int MAX_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  utv_pkg::byte_type req_tdata,   // [7:0] text_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata    // [0] string_ok, [7:1] zero
);
   import utv_pkg::*;

   localparam int CNT_W = $clog2(MAX_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_BYTES);

   // Input register
   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff,  in_byte_in;

   // String state
   logic             error_seen_ff,    error_seen_in;
   logic             has_content_ff,   has_content_in;
   logic [CNT_W-1:0] byte_count_ff,    byte_count_in;
   logic [1:0]       bytes_pending_ff, bytes_pending_in;
   code_type         code_accum_ff,    code_accum_in;
   class_type        lead_class_ff,    lead_class_in;

   // Result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ok_ff,    rsp_ok_in;

   logic     is_term;
   logic     go;
   logic     term_go;
   logic     state_clear;
   logic     string_ok;
   code_type code_next;
   code_type code_min;

   // Advance the held byte unless a terminator meets a full result slot not being taken
   assign is_term    = (in_byte_ff == BYTE_TERM);
   assign go         = in_valid_ff && (!is_term || !rsp_valid_ff || rsp_tready);
   assign term_go    = go && is_term;
   assign req_tready = !in_valid_ff || go;

   assign string_ok = !error_seen_ff && has_content_ff && (bytes_pending_ff == 2'd0) &&
                      (byte_count_ff != '0) && (byte_count_ff < CNT_LIMIT);

   assign state_clear = (byte_count_ff == '0) && (bytes_pending_ff == 2'd0) &&
                        !error_seen_ff;

   assign code_next = {code_accum_ff[CODE_W-7:0], in_byte_ff[5:0]};

   // Smallest code point each sequence length may carry
   always_comb begin
      case (lead_class_ff)
         CLASS_TWO:   code_min = MIN_TWO;
         CLASS_THREE: code_min = MIN_THREE;
         default:     code_min = MIN_FOUR;
      endcase
   end

   // Capture the next byte
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   // Check the held byte against the sequence state
   always_comb begin
      error_seen_in    = error_seen_ff;
      has_content_in   = has_content_ff;
      byte_count_in    = byte_count_ff;
      bytes_pending_in = bytes_pending_ff;
      code_accum_in    = code_accum_ff;
      lead_class_in    = lead_class_ff;
      if (go) begin
         if (is_term) begin
            error_seen_in    = 1'b0;
            has_content_in   = 1'b0;
            byte_count_in    = '0;
            bytes_pending_in = 2'd0;
            code_accum_in    = '0;
            lead_class_in    = CLASS_NONE;
         end else begin
            if (byte_count_ff < CNT_LIMIT)
               byte_count_in = byte_count_ff + CNT_W'(1);
            if (bytes_pending_ff != 2'd0) begin
               if ((in_byte_ff & CONT_MASK) != CONT_TAG) begin
                  error_seen_in    = 1'b1;
                  bytes_pending_in = 2'd0;
               end else begin
                  code_accum_in    = code_next;
                  bytes_pending_in = bytes_pending_ff - 2'd1;
                  if (bytes_pending_ff == 2'd1) begin
                     if (code_next < code_min || code_next > CODE_MAX ||
                         (code_next >= SURR_LOW && code_next <= SURR_HIGH))
                        error_seen_in = 1'b1;
                     else
                        has_content_in = 1'b1;
                  end
               end
            end else begin
               case (in_byte_ff) inside
                  [8'h01:8'h1f], BYTE_DEL: error_seen_in = 1'b1;
                  BYTE_SPACE: ;
                  [8'h21:8'h7e]: has_content_in = 1'b1;
                  [8'hc2:8'hdf]: begin
                     bytes_pending_in = 2'd1;
                     lead_class_in    = CLASS_TWO;
                     code_accum_in    = code_type'(in_byte_ff[4:0]);
                  end
                  [8'he0:8'hef]: begin
                     bytes_pending_in = 2'd2;
                     lead_class_in    = CLASS_THREE;
                     code_accum_in    = code_type'(in_byte_ff[3:0]);
                  end
                  [8'hf0:8'hf4]: begin
                     bytes_pending_in = 2'd3;
                     lead_class_in    = CLASS_FOUR;
                     code_accum_in    = code_type'(in_byte_ff[2:0]);
                  end
                  default: error_seen_in = 1'b1;
               endcase
            end
         end
      end
   end

   // Load the verdict on a terminator, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (term_go) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = string_ok;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         error_seen_ff    <= 1'b0;
         has_content_ff   <= 1'b0;
         byte_count_ff    <= '0;
         bytes_pending_ff <= 2'd0;
         code_accum_ff    <= '0;
         lead_class_ff    <= CLASS_NONE;
      end else begin
         in_valid_ff      <= in_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         error_seen_ff    <= error_seen_in;
         has_content_ff   <= has_content_in;
         byte_count_ff    <= byte_count_in;
         bytes_pending_ff <= bytes_pending_in;
         code_accum_ff    <= code_accum_in;
         lead_class_ff    <= lead_class_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ok_ff};

   // A terminator taken into the check stage always yields a result
   `ASSERT_NEXT(a_term_gives_result, clock, reset, term_go, rsp_valid_ff, "result lost")
   // A terminator leaves the string state cleared
   `ASSERT_NEXT(a_term_clears, clock, reset, term_go, state_clear, "string state not cleared")
   // Pending continuations never exceed the lead class
   `ASSERT_CLK(a_pending_in_class, clock, reset, bytes_pending_ff <= lead_class_ff, "pending > class")
   // Byte count saturates at the limit
   `ASSERT_CLK(a_count_bound, clock, reset, byte_count_ff <= CNT_LIMIT, "byte count beyond limit")

endmodule
